// ===== design/tcpfq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpfq_pkg
// Shared types, codes and defaults for the two-class priority frame queue.
// ----------------------------------------------------------------------------
package tcpfq_pkg;

    localparam int DEF_MGMT_DEPTH   = 16;
    localparam int DEF_DATA_DEPTH   = 64;
    localparam int DEF_HANDLE_WIDTH = 16;

    localparam int FIELD_HANDLE_W = 16;
    localparam int CAP_W          = 7;
    localparam int LEN_W          = 7;
    localparam int STATUS_W       = 3;
    localparam int CMD_W          = 2;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // register index of data_capacity
    localparam logic REG_DATA_CAPACITY = 1'b0;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DATA_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MGMT_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_OPER  = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;   // latch the input beat
        logic exec;      // run the command, access the stores
        logic load_out;  // move the result into the output register
    } t_dp_cmd;

endpackage

// ===== design/tcpfq_regs.sv =====
// ----------------------------------------------------------------------------
// tcpfq_regs
// APB-style configuration register file holding data_capacity.
// ----------------------------------------------------------------------------
module tcpfq_regs
    import tcpfq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CAP_W-1:0]  o_data_capacity
);

    logic [CAP_W-1:0] r_data_capacity;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DATA_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_capacity <= '0;
        end else if (wr_en) begin
            r_data_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DATA_CAPACITY) begin
            prdata = APB_DW'(r_data_capacity);
        end
    end

    assign o_data_capacity = r_data_capacity;

endmodule

// ===== design/tcpfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpfq_ctrl
// Sequencer: accept a beat, execute it, then load the output register.
// ----------------------------------------------------------------------------
module tcpfq_ctrl
    import tcpfq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_FIN: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/tcpfq_datapath.sv =====
// ----------------------------------------------------------------------------
// tcpfq_datapath
// Two handle FIFOs in memories, pointers, drop checks and result register.
// ----------------------------------------------------------------------------
module tcpfq_datapath
    import tcpfq_pkg::*;
#(
    parameter int MGMT_DEPTH   = DEF_MGMT_DEPTH,
    parameter int DATA_DEPTH   = DEF_DATA_DEPTH,
    parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [CAP_W-1:0]          i_data_capacity,
    input  logic [CMD_W-1:0]          i_command,
    input  logic                      i_is_management,
    input  logic [FIELD_HANDLE_W-1:0] i_frame_handle,
    output logic [STATUS_W-1:0]       o_status,
    output logic [FIELD_HANDLE_W-1:0] o_out_handle,
    output logic                      o_out_is_management,
    output logic [LEN_W-1:0]          o_data_length,
    output logic                      o_queues_empty
);

    // only the low bits that both the field and the handle width carry are kept
    localparam int SW  = (HANDLE_WIDTH < FIELD_HANDLE_W) ? HANDLE_WIDTH : FIELD_HANDLE_W;
    localparam int MAW = $clog2(MGMT_DEPTH);
    localparam int MCW = $clog2(MGMT_DEPTH + 1);
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int LW  = (DCW > CAP_W) ? DCW : CAP_W;

    logic [SW-1:0] mgmt_mem [MGMT_DEPTH];
    logic [SW-1:0] data_mem [DATA_DEPTH];

    logic [CMD_W-1:0] r_cmd;
    logic             r_is_mgmt;
    logic [SW-1:0]    r_handle;

    logic [MAW-1:0] r_mgmt_head, n_mgmt_head, r_mgmt_tail, n_mgmt_tail;
    logic [MCW-1:0] r_mgmt_count, n_mgmt_count;
    logic [DAW-1:0] r_data_head, n_data_head, r_data_tail, n_data_tail;
    logic [DCW-1:0] r_data_count, n_data_count;
    logic           r_oper, n_oper;

    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_take_mgmt, n_take_mgmt;
    logic                r_take_data, n_take_data;
    logic [SW-1:0]       r_mgmt_rd, r_data_rd;

    logic [STATUS_W-1:0]       r_out_status;
    logic [FIELD_HANDLE_W-1:0] r_out_handle;
    logic                      r_out_mgmt;
    logic [LEN_W-1:0]          r_out_len;
    logic                      r_out_empty;

    logic          mgmt_we, data_we;
    logic [LW-1:0] cap_ext, depth_ext, limit, count_ext;
    logic          data_full, mgmt_full;

    function automatic logic [MAW-1:0] mgmt_inc(input logic [MAW-1:0] p);
        mgmt_inc = (p == MAW'(MGMT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [DAW-1:0] data_inc(input logic [DAW-1:0] p);
        data_inc = (p == DAW'(DATA_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // a capacity of zero or beyond the depth falls back to the depth
    assign cap_ext   = LW'(i_data_capacity);
    assign depth_ext = LW'(DATA_DEPTH);
    assign limit     = (i_data_capacity == '0 || cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign count_ext = LW'(r_data_count);
    assign data_full = count_ext >= limit;
    assign mgmt_full = r_mgmt_count >= MCW'(MGMT_DEPTH);

    always_comb begin
        n_mgmt_head  = r_mgmt_head;
        n_mgmt_tail  = r_mgmt_tail;
        n_mgmt_count = r_mgmt_count;
        n_data_head  = r_data_head;
        n_data_tail  = r_data_tail;
        n_data_count = r_data_count;
        n_oper       = r_oper;
        n_status     = ST_DONE;
        n_take_mgmt  = 1'b0;
        n_take_data  = 1'b0;
        mgmt_we      = 1'b0;
        data_we      = 1'b0;
        if (i_cmd.exec) begin
            case (r_cmd)
                CMD_START: begin
                    n_oper = 1'b1;
                end
                CMD_STOP: begin
                    n_mgmt_head  = '0;
                    n_mgmt_tail  = '0;
                    n_mgmt_count = '0;
                    n_data_head  = '0;
                    n_data_tail  = '0;
                    n_data_count = '0;
                    n_oper       = 1'b0;
                end
                CMD_ENQUEUE: begin
                    if (!r_oper) begin
                        n_status = ST_NOT_OPER;
                    end else if (r_is_mgmt) begin
                        if (mgmt_full) begin
                            n_status = ST_MGMT_FULL;
                        end else begin
                            mgmt_we      = 1'b1;
                            n_mgmt_tail  = mgmt_inc(r_mgmt_tail);
                            n_mgmt_count = r_mgmt_count + 1'b1;
                            n_status     = ST_QUEUED;
                        end
                    end else begin
                        if (data_full) begin
                            n_status = ST_DATA_FULL;
                        end else begin
                            data_we      = 1'b1;
                            n_data_tail  = data_inc(r_data_tail);
                            n_data_count = r_data_count + 1'b1;
                            n_status     = ST_QUEUED;
                        end
                    end
                end
                CMD_DEQUEUE: begin
                    if (!r_oper) begin
                        n_status = ST_NOT_OPER;
                    end else if (r_mgmt_count != '0) begin
                        n_mgmt_head  = mgmt_inc(r_mgmt_head);
                        n_mgmt_count = r_mgmt_count - 1'b1;
                        n_take_mgmt  = 1'b1;
                        n_status     = ST_DEQUEUED;
                    end else if (r_data_count != '0) begin
                        n_data_head  = data_inc(r_data_head);
                        n_data_count = r_data_count - 1'b1;
                        n_take_data  = 1'b1;
                        n_status     = ST_DEQUEUED;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= i_command;
            r_is_mgmt <= i_is_management;
            r_handle  <= i_frame_handle[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mgmt_head  <= '0;
            r_mgmt_tail  <= '0;
            r_mgmt_count <= '0;
            r_data_head  <= '0;
            r_data_tail  <= '0;
            r_data_count <= '0;
            r_oper       <= 1'b1;
        end else begin
            r_mgmt_head  <= n_mgmt_head;
            r_mgmt_tail  <= n_mgmt_tail;
            r_mgmt_count <= n_mgmt_count;
            r_data_head  <= n_data_head;
            r_data_tail  <= n_data_tail;
            r_data_count <= n_data_count;
            r_oper       <= n_oper;
        end
    end

    // head entries are read in the execute cycle; the data is used when the output register loads
    always_ff @(posedge i_clk) begin
        if (mgmt_we) begin
            mgmt_mem[r_mgmt_tail] <= r_handle;
        end
        if (i_cmd.exec) begin
            r_mgmt_rd <= mgmt_mem[r_mgmt_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[r_data_tail] <= r_handle;
        end
        if (i_cmd.exec) begin
            r_data_rd <= data_mem[r_data_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_take_mgmt <= n_take_mgmt;
            r_take_data <= n_take_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            if (r_take_mgmt) begin
                r_out_handle <= FIELD_HANDLE_W'(r_mgmt_rd);
            end else if (r_take_data) begin
                r_out_handle <= FIELD_HANDLE_W'(r_data_rd);
            end else begin
                r_out_handle <= '0;
            end
            r_out_mgmt  <= r_take_mgmt;
            // length saturates at the top of the field
            r_out_len   <= (count_ext > LW'(2**LEN_W - 1)) ? '1 : count_ext[LEN_W-1:0];
            r_out_empty <= (r_mgmt_count == '0) && (r_data_count == '0);
        end
    end

    assign o_status            = r_out_status;
    assign o_out_handle        = r_out_handle;
    assign o_out_is_management = r_out_mgmt;
    assign o_data_length       = r_out_len;
    assign o_queues_empty      = r_out_empty;

endmodule

// ===== design/two_class_priority_frame_queue.sv =====
// Flow: an accepted input beat passes the execute state (with registered store read)
//   and then the finish state, where the output register loads once it is free.
// Occupancy: the sequencer handles one item at a time, and the next beat is taken
//   while the previous result still waits.
// Reset (i_rst_n, synchronous, active low): both queues empty, operational,
//   data_capacity 0. No clearing pass; store contents are left as they are.
// ----------------------------------------------------------------------------
// two_class_priority_frame_queue
// Strict-priority management/data frame handle queue with tail drop.
// ----------------------------------------------------------------------------
module two_class_priority_frame_queue
    import tcpfq_pkg::*;
#(
    parameter int MGMT_DEPTH   = DEF_MGMT_DEPTH,
    parameter int DATA_DEPTH   = DEF_DATA_DEPTH,
    parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [CMD_W-1:0]          i_command,
    input  logic                      i_is_management,
    input  logic [FIELD_HANDLE_W-1:0] i_frame_handle,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STATUS_W-1:0]       o_status,
    output logic [FIELD_HANDLE_W-1:0] o_out_handle,
    output logic                      o_out_is_management,
    output logic [LEN_W-1:0]          o_data_length,
    output logic                      o_queues_empty
);

    logic [CAP_W-1:0] data_capacity;
    t_dp_cmd          dp_cmd;

    tcpfq_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_data_capacity (data_capacity)
    );

    tcpfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd)
    );

    tcpfq_datapath #(
        .MGMT_DEPTH   (MGMT_DEPTH),
        .DATA_DEPTH   (DATA_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .i_data_capacity     (data_capacity),
        .i_command           (i_command),
        .i_is_management     (i_is_management),
        .i_frame_handle      (i_frame_handle),
        .o_status            (o_status),
        .o_out_handle        (o_out_handle),
        .o_out_is_management (o_out_is_management),
        .o_data_length       (o_data_length),
        .o_queues_empty      (o_queues_empty)
    );

endmodule

// ===== design/tcpfq_checker.sv =====
// ----------------------------------------------------------------------------
// tcpfq_checker
// Port-level checks for the priority frame queue, bound to the top level.
// ----------------------------------------------------------------------------
module tcpfq_checker
    import tcpfq_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [STATUS_W-1:0]       o_status,
    input logic [FIELD_HANDLE_W-1:0] o_out_handle,
    input logic                      o_out_is_management,
    input logic [LEN_W-1:0]          o_data_length,
    input logic                      o_queues_empty
);

    // a result beat is held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_out_handle))
        else $error("stalled result beat changed");

    // one item in flight: busy right after an input beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // handle and class flag only carry data on a dequeue
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DEQUEUED) |-> (o_out_handle == '0)
            && !o_out_is_management)
        else $error("handle reported without a dequeue");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_queues_empty |-> (o_data_length == '0))
        else $error("queues empty but data length nonzero");

endmodule

bind two_class_priority_frame_queue tcpfq_checker u_chk (.*);
